FILE: src/ipc_pkg.sv
`default_nettype none
package ipc_pkg;

   localparam int QUEUE_COUNT = 64;

   localparam int POS_W = 7;
   localparam int MASK_W = 64;
   localparam int QID_W = 6;

   // byte offsets inside the frame
   localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
   localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
   localparam logic [POS_W-1:0] POS_IHL = 7'd14;
   localparam logic [POS_W-1:0] POS_PROTO = 7'd23;
   localparam logic [POS_W-1:0] POS_MAX = 7'd127;
   localparam logic [POS_W-1:0] ETH_HDR_BYTES = 7'd14;

   // minimum last-byte positions (length - 1)
   localparam logic [POS_W-1:0] LAST_POS_ETH = 7'd13;
   localparam logic [POS_W-1:0] LAST_POS_IPV4 = 7'd33;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;

   localparam logic [15:0] MIRROR_ETYPE_RST = 16'h88B8;
   localparam logic [15:0] PORT_A_RST = 16'd102;
   localparam logic [15:0] PORT_B_RST = 16'd502;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOCKET_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_ETYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_B = 2'd3;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // one parsed frame handed from front to back
   typedef struct packed {
      logic [POS_W-1:0] last_pos;
      logic [15:0]      etype;
      logic [3:0]       hdr_words;
      logic [7:0]       proto;
      logic [15:0]      src_port;
      logic [15:0]      dst_port;
      logic [QID_W-1:0] rx_queue;
   } ipc_record_type;

   typedef struct packed {
      logic [MASK_W-1:0] socket_mask;
      logic [15:0]       mirror_etype;
      logic [15:0]       port_a;
      logic [15:0]       port_b;
   } ipc_cfg_type;

   typedef struct packed {
      logic valid;
      logic full;
   } ipc_qstat_type;

endpackage
`default_nettype wire

FILE: src/ipc_front.sv
`default_nettype none
module ipc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   beat_take,
   input  wire logic [7:0]             frame_byte,
   input  wire logic                   last_byte,
   input  wire logic [ipc_pkg::QID_W-1:0] rx_queue,
   output logic                        rec_push,
   output ipc_pkg::ipc_record_type     rec_data
);
   import ipc_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      etype_ff, etype_in;
   logic [3:0]       hw_ff, hw_in;
   logic [7:0]       proto_ff, proto_in;
   logic [15:0]      sport_ff, sport_in;
   logic [15:0]      dport_ff, dport_in;
   logic [POS_W-1:0] ports_at;
   logic [POS_W:0]   port_off;

   // header length is live at byte 14, so the port window may start there
   assign ports_at = ETH_HDR_BYTES + {1'b0, hw_in, 2'b00};
   assign port_off = {1'b0, pos_ff} - {1'b0, ports_at};

   always_comb begin
      etype_in = etype_ff;
      hw_in    = hw_ff;
      proto_in = proto_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      if (pos_ff == POS_ETYPE_HI) begin
         etype_in = {frame_byte, etype_ff[7:0]};
      end else if (pos_ff == POS_ETYPE_LO) begin
         etype_in = {etype_ff[15:8], frame_byte};
      end
      if (pos_ff == POS_IHL) begin
         hw_in = frame_byte[3:0];
      end
      if (pos_ff == POS_PROTO) begin
         proto_in = frame_byte;
      end
      if (port_off[POS_W:2] == '0) begin
         case (port_off[1:0])
            2'd0: sport_in = {frame_byte, sport_ff[7:0]};
            2'd1: sport_in = {sport_ff[15:8], frame_byte};
            2'd2: dport_in = {frame_byte, dport_ff[7:0]};
            2'd3: dport_in = {dport_ff[15:8], frame_byte};
            default: sport_in = sport_ff;
         endcase
      end
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   end

   assign rec_push = beat_take && last_byte;

   always_comb begin
      rec_data.last_pos  = pos_ff;
      rec_data.etype     = etype_in;
      rec_data.hdr_words = hw_in;
      rec_data.proto     = proto_in;
      rec_data.src_port  = sport_in;
      rec_data.dst_port  = dport_in;
      rec_data.rx_queue  = rx_queue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         etype_ff <= '0;
         hw_ff    <= '0;
         proto_ff <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
      end else if (beat_take) begin
         if (last_byte) begin
            pos_ff   <= '0;
            etype_ff <= '0;
            hw_ff    <= '0;
            proto_ff <= '0;
            sport_ff <= '0;
            dport_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            etype_ff <= etype_in;
            hw_ff    <= hw_in;
            proto_ff <= proto_in;
            sport_ff <= sport_in;
            dport_ff <= dport_in;
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/ipc_queue.sv
`default_nettype none
module ipc_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ipc_pkg::ipc_record_type push_data,
   input  wire logic                    pop,
   output ipc_pkg::ipc_record_type      head,
   output ipc_pkg::ipc_qstat_type       stat
);
   import ipc_pkg::*;

   ipc_record_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == QCNT_W'(QDEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/ipc_back.sv
`default_nettype none
module ipc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ipc_pkg::ipc_cfg_type    cfg,
   input  wire ipc_pkg::ipc_record_type rec,
   input  wire ipc_pkg::ipc_qstat_type  qstat,
   output logic                         rec_pop,
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output logic                         out_verdict,
   output logic [ipc_pkg::QID_W-1:0]    out_queue
);
   import ipc_pkg::*;

   logic             valid_ff;
   logic             verdict_ff, verdict_in;
   logic [QID_W-1:0] queue_ff, queue_in;
   logic [POS_W-1:0] tcp_last_pos;
   logic             port_hit, mirror_hit, tcp_hit, queue_ok;

   // frame must be at least 14 + 4*IHL + 20 bytes long
   assign tcp_last_pos = LAST_POS_IPV4 + {1'b0, rec.hdr_words, 2'b00};

   assign port_hit = (rec.src_port == cfg.port_a) || (rec.dst_port == cfg.port_a) ||
                     (rec.src_port == cfg.port_b) || (rec.dst_port == cfg.port_b);

   assign mirror_hit = (rec.last_pos >= LAST_POS_ETH) && (rec.etype == cfg.mirror_etype);

   assign tcp_hit = (rec.last_pos >= LAST_POS_ETH) && (rec.etype == ETYPE_IPV4) &&
                    (rec.last_pos >= LAST_POS_IPV4) && (rec.proto == PROTO_TCP) &&
                    (rec.last_pos >= tcp_last_pos) && port_hit;

   assign queue_ok = ({1'b0, rec.rx_queue} < (QID_W + 1)'(QUEUE_COUNT)) &&
                     cfg.socket_mask[rec.rx_queue];

   assign verdict_in = (mirror_hit || tcp_hit) && queue_ok;
   assign queue_in   = verdict_in ? rec.rx_queue : '0;

   assign rec_pop = qstat.valid && (!valid_ff || !out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rec_pop) begin
         valid_ff <= 1'b1;
      end else if (!out_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         verdict_ff <= verdict_in;
         queue_ff   <= queue_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_verdict = verdict_ff;
   assign out_queue   = queue_ff;

endmodule
`default_nettype wire

FILE: src/industrial_packet_classifier.sv
// Path: when a frame's last byte beat is taken, its record goes into the front-to-back
//   queue, then into the back's output register, which drives the verdict beat.
// Throughput: one frame byte, or one one-byte frame, per cycle while req_stall is low.
//   The two-entry queue sets how far the back may lag before req_stall rises.
// Reset: synchronous, active high; clears the parser, queue and output valid, and loads
//   the registers with mask 0, mirror type 0x88B8, ports 102 and 502.
`default_nettype none
module industrial_packet_classifier (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // frame byte channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_frame_byte,
   input  wire logic                          req_last_byte,
   input  wire logic [ipc_pkg::QID_W-1:0]     req_rx_queue,
   // verdict channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_verdict,
   output logic [ipc_pkg::QID_W-1:0]          rsp_target_queue,
   // register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ipc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ipc_pkg::MASK_W-1:0]    csr_wdata
);
   import ipc_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; the block is
   // expected to be idle while they change.
   // ---------------------------------------------------------------------
   logic [MASK_W-1:0] mask_ff;
   logic [15:0]       mirror_ff;
   logic [15:0]       port_a_ff;
   logic [15:0]       port_b_ff;
   logic              csr_take;
   ipc_cfg_type       cfg;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         mirror_ff <= MIRROR_ETYPE_RST;
         port_a_ff <= PORT_A_RST;
         port_b_ff <= PORT_B_RST;
      end else if (csr_take) begin
         case (csr_index)
            CSR_SOCKET_MASK:  mask_ff   <= csr_wdata;
            CSR_MIRROR_ETYPE: mirror_ff <= csr_wdata[15:0];
            CSR_PORT_A:       port_a_ff <= csr_wdata[15:0];
            CSR_PORT_B:       port_b_ff <= csr_wdata[15:0];
            default:          mask_ff   <= mask_ff;
         endcase
      end
   end

   always_comb begin
      cfg.socket_mask  = mask_ff;
      cfg.mirror_etype = mirror_ff;
      cfg.port_a       = port_a_ff;
      cfg.port_b       = port_b_ff;
   end

   // ---------------------------------------------------------------------
   // Front: byte position tracking and header capture. Every byte beat is
   // taken unless the queue is full; the last byte pushes one record.
   // ---------------------------------------------------------------------
   logic           req_take;
   logic           q_push;
   logic           q_pop;
   ipc_record_type q_in;
   ipc_record_type q_head;
   ipc_qstat_type  q_stat;

   assign req_stall = q_stat.full;
   assign req_take  = req_valid && !req_stall;

   ipc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .beat_take  (req_take),
      .frame_byte (req_frame_byte),
      .last_byte  (req_last_byte),
      .rx_queue   (req_rx_queue),
      .rec_push   (q_push),
      .rec_data   (q_in)
   );

   // short queue so the byte stream keeps moving while a verdict waits
   ipc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // ---------------------------------------------------------------------
   // Back: match rules, socket mask lookup, registered verdict beat.
   // ---------------------------------------------------------------------
   ipc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .rec         (q_head),
      .qstat       (q_stat),
      .rec_pop     (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_verdict (rsp_verdict),
      .out_queue   (rsp_target_queue)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a pass verdict carries queue zero
   a_pass_queue_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_verdict) |-> (rsp_target_queue == '0))
      else $error("pass verdict with nonzero target queue");

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("record pushed into full queue");

   // a new verdict beat only comes from a record that was waiting
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_stat.valid))
      else $error("verdict beat without a queued record");

endmodule
`default_nettype wire

FILE: tb/sv/tb_industrial_packet_classifier.sv
`timescale 1ns / 1ps
module tb_industrial_packet_classifier;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 7;
   // pause after every owed verdict is back, before csr writes
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BYTES  = 150;
   localparam int MIN_FRAMES    = 2;        // per random phase
   localparam int CYCLE_LIMIT   = 300000;
   localparam int REPORT_LIMIT  = 10;

   localparam int QW = ipc_pkg::QID_W;

   // frame layout, in bytes
   localparam int ETH_BYTES    = 14;
   localparam int IP_MIN_BYTES = 20;
   localparam int TCP_BYTES    = 20;
   localparam int POS_CAP      = 127;

   localparam logic [15:0] IPV4 = ipc_pkg::ETYPE_IPV4;
   localparam logic [7:0]  TCP  = ipc_pkg::PROTO_TCP;

   // register values out of reset
   localparam logic [15:0] MIRROR_AT_RESET = 16'h88B8;
   localparam logic [15:0] PORT_A_AT_RESET = 16'd102;
   localparam logic [15:0] PORT_B_AT_RESET = 16'd502;

   typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_type;
   typedef enum logic {ROW_REG, ROW_FRAME} row_kind_type;

   typedef struct packed {
      logic          verdict;
      logic [QW-1:0] target;
   } verdict_type;

   // one line of the directed table: either a register write or a whole frame
   typedef struct {
      row_kind_type                  kind;
      logic [ipc_pkg::CSR_IDX_W-1:0] reg_idx;
      logic [63:0]                   reg_val;
      int                            len;
      logic [15:0]                   etype;
      logic [7:0]                    ihl;
      logic [7:0]                    proto;
      logic [15:0]                   sport;
      logic [15:0]                   dport;
      fill_type                      fill;
      logic [QW-1:0]                 rx_q;
      bit                            typed;     // verdict written in the table
      verdict_type                   typed_v;
   } dir_row_type;

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [7:0]                    req_frame_byte;
   logic                          req_last_byte;
   logic [QW-1:0]                 req_rx_queue;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_verdict;
   logic [QW-1:0]                 rsp_target_queue;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [ipc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [63:0]                   csr_wdata;

   industrial_packet_classifier u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_byte   (req_frame_byte),
      .req_last_byte    (req_last_byte),
      .req_rx_queue     (req_rx_queue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_target_queue (rsp_target_queue),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------
   verdict_type pending_verdicts[$];   // verdicts owed by the DUT, oldest first
   logic [7:0]  frame_buf[$];          // bytes of the frame being sent
   dir_row_type dir_rows[$];

   int unsigned cycle_count;
   int unsigned mismatch_count = 0;
   int unsigned verdicts_seen  = 0;
   int unsigned bytes_sent     = 0;
   int unsigned frames_sent    = 0;
   int unsigned drain_pauses   = 0;

   // idle mix: chance in a hundred, per cycle
   int send_idle_pct = 30;
   int stall_pct     = 63;

   // ------------------------------------------------------------------
   // Classifier model: registers plus per-frame capture state
   // ------------------------------------------------------------------
   logic [63:0]  cfg_mask;
   logic [15:0]  cfg_mirror;
   logic [15:0]  cfg_port_a;
   logic [15:0]  cfg_port_b;

   logic [6:0]   run_pos;
   logic [15:0]  run_etype;
   logic [3:0]   run_hwords;
   logic [7:0]   run_proto;
   logic [15:0]  run_sport;
   logic [15:0]  run_dport;

   function automatic void clear_capture();
      run_pos    = '0;
      run_etype  = '0;
      run_hwords = '0;
      run_proto  = '0;
      run_sport  = '0;
      run_dport  = '0;
   endfunction

   // Feed one byte beat; on the last byte it hands back the verdict and clears.
   function automatic void classify_byte(input logic [7:0] b, input logic last,
                                         input logic [QW-1:0] q,
                                         output bit has_v, output verdict_type v);
      int unsigned pos;
      int unsigned ports_at;
      int unsigned len;
      bit          hit;
      pos = run_pos;
      if (pos == 12) run_etype[15:8] = b;
      else if (pos == 13) run_etype[7:0] = b;
      if (pos == 14) run_hwords = b[3:0];
      if (pos == 23) run_proto = b;
      // port offset follows the header length as captured so far, even this very beat
      ports_at = ETH_BYTES + 4 * run_hwords;
      if (pos == ports_at) run_sport[15:8] = b;
      else if (pos == ports_at + 1) run_sport[7:0] = b;
      else if (pos == ports_at + 2) run_dport[15:8] = b;
      else if (pos == ports_at + 3) run_dport[7:0] = b;
      if (pos < POS_CAP) run_pos = 7'(pos + 1);
      has_v = last;
      v     = '0;
      if (last) begin
         len = pos + 1;
         hit = 1'b0;
         if (len >= ETH_BYTES) begin
            if (run_etype == cfg_mirror) begin
               hit = 1'b1;
            end else if (run_etype == IPV4 && len >= ETH_BYTES + IP_MIN_BYTES &&
                         run_proto == TCP &&
                         len >= ETH_BYTES + 4 * run_hwords + TCP_BYTES) begin
               hit = (run_sport == cfg_port_a) || (run_dport == cfg_port_a) ||
                     (run_sport == cfg_port_b) || (run_dport == cfg_port_b);
            end
         end
         // redirect only onto a queue with a bound socket
         if (hit && int'(q) < ipc_pkg::QUEUE_COUNT && cfg_mask[q]) begin
            v.verdict = 1'b1;
            v.target  = q;
         end
         clear_capture();
      end
   endfunction

   // ------------------------------------------------------------------
   // Frame construction
   // ------------------------------------------------------------------
   // Ports go in first, header bytes after, so a short header length lets
   // the header bytes land on top of the port bytes.
   function automatic void build_frame(input int len, input logic [15:0] etype,
                                       input logic [7:0] ihl, input logic [7:0] proto,
                                       input logic [15:0] sport, input logic [15:0] dport,
                                       input fill_type fill);
      int pa;
      frame_buf.delete();
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: frame_buf.push_back(8'h00);
            FILL_ONES: frame_buf.push_back(8'hFF);
            default:   frame_buf.push_back(8'($urandom));
         endcase
      end
      pa = ETH_BYTES + 4 * ihl[3:0];
      if (pa < len)     frame_buf[pa]     = sport[15:8];
      if (pa + 1 < len) frame_buf[pa + 1] = sport[7:0];
      if (pa + 2 < len) frame_buf[pa + 2] = dport[15:8];
      if (pa + 3 < len) frame_buf[pa + 3] = dport[7:0];
      if (12 < len) frame_buf[12] = etype[15:8];
      if (13 < len) frame_buf[13] = etype[7:0];
      if (14 < len) frame_buf[14] = ihl;
      if (23 < len) frame_buf[23] = proto;
   endfunction

   // half the time a configured port, so TCP frames hit often
   function automatic logic [15:0] pick_port();
      case ($urandom_range(3))
         0:       return cfg_port_a;
         1:       return cfg_port_b;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic build_random_frame();
      int          kind;
      int          hw;
      int          len;
      int          r;
      logic [7:0]  proto;
      logic [15:0] etype;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // IPv4/TCP, now and then cut short or with another protocol; mostly a 20-byte header, a few long or short ones
         r  = $urandom_range(99);
         hw = (r < 80) ? 5 : (r < 90) ? $urandom_range(6, 15) : $urandom_range(0, 4);
         len = ETH_BYTES + 4 * hw + TCP_BYTES;
         if ($urandom_range(9) == 0) len -= $urandom_range(1, 3);   // cut short
         else len += $urandom_range(0, 6);
         proto = ($urandom_range(9) == 0) ? 8'($urandom) : TCP;
         build_frame(len, IPV4, {4'($urandom), 4'(hw)}, proto, pick_port(), pick_port(),
                     FILL_RAND);
      end else if (kind < 70) begin
         // mirror type, sometimes under 14 bytes
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 13) : $urandom_range(14, 24);
         build_frame(len, cfg_mirror, 8'($urandom), 8'($urandom), pick_port(),
                     pick_port(), FILL_RAND);
      end else if (kind < 85) begin
         // broken: odd ethertype or odd length, protocol often TCP anyway
         len   = $urandom_range(1, 40);
         etype = $urandom_range(1) ? IPV4 : 16'($urandom);
         proto = $urandom_range(1) ? TCP : 8'($urandom);
         build_frame(len, etype, 8'($urandom), proto, pick_port(), pick_port(), FILL_RAND);
      end else begin
         // runt noise, one-byte frames included
         build_frame($urandom_range(1, 8), 16'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), FILL_RAND);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   function automatic void add_frame(input int len, input logic [15:0] etype,
                                     input logic [7:0] ihl, input logic [7:0] proto,
                                     input logic [15:0] sport, input logic [15:0] dport,
                                     input fill_type fill, input logic [QW-1:0] rx_q,
                                     input bit typed, input logic v, input logic [QW-1:0] tq);
      dir_row_type r;
      r.kind    = ROW_FRAME;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.len     = len;
      r.etype   = etype;
      r.ihl     = ihl;
      r.proto   = proto;
      r.sport   = sport;
      r.dport   = dport;
      r.fill    = fill;
      r.rx_q    = rx_q;
      r.typed   = typed;
      r.typed_v.verdict = v;
      r.typed_v.target  = tq;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_reg(input logic [ipc_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [63:0] val);
      dir_row_type r;
      r.kind    = ROW_REG;
      r.reg_idx = idx;
      r.reg_val = val;
      r.typed   = 1'b0;
      dir_rows.push_back(r);
   endfunction

   function automatic void fill_directed_table();
      // reset registers: mask is empty, so even a mirror frame passes
      add_frame(14, MIRROR_AT_RESET, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ZERO, 6'd5,
                1, 1'b0, 6'd0);
      add_reg(ipc_pkg::CSR_SOCKET_MASK, '1);
      add_frame(14, MIRROR_AT_RESET, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ONES, 6'd0,
                1, 1'b1, 6'd0);
      // truncated mirror frame, then a one-byte frame
      add_frame(13, MIRROR_AT_RESET, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ZERO, 6'd9,
                1, 1'b0, 6'd0);
      add_frame(1, MIRROR_AT_RESET, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ONES, 6'd63,
                1, 1'b0, 6'd0);
      // plain TCP on a configured port, as source and as destination
      add_frame(54, IPV4, 8'h45, TCP, PORT_A_AT_RESET, 16'd80, FILL_ZERO, 6'd63,
                1, 1'b1, 6'd63);
      add_frame(54, IPV4, 8'h45, TCP, 16'd1234, PORT_B_AT_RESET, FILL_RAND, 6'd17,
                1, 1'b1, 6'd17);
      // one byte short of the TCP header; UDP; under the IPv4 minimum
      add_frame(53, IPV4, 8'h45, TCP, PORT_A_AT_RESET, PORT_B_AT_RESET, FILL_RAND, 6'd8,
                1, 1'b0, 6'd0);
      add_frame(54, IPV4, 8'h45, 8'd17, PORT_A_AT_RESET, PORT_B_AT_RESET, FILL_RAND, 6'd8,
                1, 1'b0, 6'd0);
      add_frame(33, IPV4, 8'h45, TCP, PORT_A_AT_RESET, PORT_A_AT_RESET, FILL_ZERO, 6'd1,
                1, 1'b0, 6'd0);
      // largest header length, exact fit and one byte short
      add_frame(94, IPV4, 8'h4F, TCP, PORT_B_AT_RESET, 16'd0, FILL_ZERO, 6'd33,
                1, 1'b1, 6'd33);
      add_frame(93, IPV4, 8'h4F, TCP, PORT_B_AT_RESET, PORT_B_AT_RESET, FILL_ZERO, 6'd33,
                1, 1'b0, 6'd0);
      // short header lengths: ports overlap the IPv4 header
      add_frame(40, IPV4, 8'h40, TCP, PORT_A_AT_RESET, PORT_B_AT_RESET, FILL_RAND, 6'd12,
                0, 1'b0, 6'd0);
      add_frame(40, IPV4, 8'h42, TCP, PORT_B_AT_RESET, PORT_B_AT_RESET, FILL_RAND, 6'd12,
                0, 1'b0, 6'd0);
      // long frames, position counter saturates
      add_frame(130, MIRROR_AT_RESET, 8'h00, 8'h00, 16'd0, 16'd0, FILL_RAND, 6'd44,
                0, 1'b0, 6'd0);
      add_frame(130, IPV4, 8'h45, TCP, PORT_A_AT_RESET, 16'd7, FILL_ONES, 6'd2,
                0, 1'b0, 6'd0);
      // register extremes; mask alternates so odd queues have no socket
      add_reg(ipc_pkg::CSR_MIRROR_ETYPE, 64'hFFFF);
      add_reg(ipc_pkg::CSR_PORT_A, 64'h0);
      add_reg(ipc_pkg::CSR_PORT_B, 64'hFFFF);
      add_reg(ipc_pkg::CSR_SOCKET_MASK, 64'h5555_5555_5555_5555);
      add_frame(14, 16'hFFFF, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ONES, 6'd2, 1, 1'b1, 6'd2);
      add_frame(14, 16'hFFFF, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ONES, 6'd3, 1, 1'b0, 6'd0);
      add_frame(54, IPV4, 8'h45, TCP, 16'd0, 16'd1, FILL_ZERO, 6'd62, 0, 1'b0, 6'd0);
      add_frame(54, IPV4, 8'h45, TCP, 16'd1, 16'hFFFF, FILL_RAND, 6'd0, 0, 1'b0, 6'd0);
      add_frame(54, MIRROR_AT_RESET, 8'h45, TCP, 16'd5, 16'd5, FILL_RAND, 6'd0,
                0, 1'b0, 6'd0);
      // mirror type set to IPv4 itself, then to zero
      add_reg(ipc_pkg::CSR_MIRROR_ETYPE, {48'hFFFF_FFFF_FFFF, IPV4});
      add_frame(14, IPV4, 8'h00, 8'h00, 16'd0, 16'd0, FILL_RAND, 6'd0, 1, 1'b1, 6'd0);
      add_reg(ipc_pkg::CSR_MIRROR_ETYPE, 64'h0);
      add_frame(20, 16'h0000, 8'h00, 8'h00, 16'd0, 16'd0, FILL_ZERO, 6'd4, 1, 1'b1, 6'd4);
   endfunction

   // ------------------------------------------------------------------
   // Clock, stall source, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // receiver back-pressure, changed on the falling edge only
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d verdicts still owed", CYCLE_LIMIT,
               pending_verdicts.size());
      $display("FAIL industrial_packet_classifier");
      $finish;
   end

   // ------------------------------------------------------------------
   // Verdict checker: every taken verdict beat against the oldest owed one
   // ------------------------------------------------------------------
   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
   endtask

   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("unexpected verdict beat: verdict %0b queue %0d",
                                   rsp_verdict, rsp_target_queue));
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_verdict !== exp_v.verdict || rsp_target_queue !== exp_v.target) begin
               note_failure($sformatf(
                  "verdict %0d: verdict exp %0b got %0b, queue exp %0d got %0d",
                  verdicts_seen, exp_v.verdict, rsp_verdict,
                  exp_v.target, rsp_target_queue));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers: everything moves on the falling edge
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last, input logic [QW-1:0] q);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_byte <= b;
      req_last_byte  <= last;
      req_rx_queue   <= q;
      // hold the beat until a rising edge with stall low takes it
      do @(posedge clock); while (req_stall);
   endtask

   // rx_queue only matters on the last byte; earlier beats carry noise there
   task automatic send_frame(input logic [QW-1:0] q, input bit typed,
                             input verdict_type typed_v);
      bit            has_v;
      verdict_type   v;
      logic [QW-1:0] q_now;
      logic          last;
      for (int i = 0; i < frame_buf.size(); i++) begin
         last  = (i == frame_buf.size() - 1);
         q_now = last ? q : QW'($urandom_range(63));
         send_byte(frame_buf[i], last, q_now);
         classify_byte(frame_buf[i], last, q_now, has_v, v);
         bytes_sent++;
         if (has_v) begin
            pending_verdicts.push_back(typed ? typed_v : v);
            frames_sent++;
         end
      end
   endtask

   // drop valid, let every owed verdict come back, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      drain_pauses++;
   endtask

   task automatic write_reg(input logic [ipc_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] val);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ipc_pkg::CSR_SOCKET_MASK:  cfg_mask   = val;
         ipc_pkg::CSR_MIRROR_ETYPE: cfg_mirror = val[15:0];
         ipc_pkg::CSR_PORT_A:       cfg_port_a = val[15:0];
         ipc_pkg::CSR_PORT_B:       cfg_port_b = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [63:0] mask;
      logic [15:0] pa;
      logic [15:0] pb;
      int          phase_bytes;
      int          phase_frames;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_frame_byte = '0;
      req_last_byte  = 1'b0;
      req_rx_queue   = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;

      cfg_mask   = '0;
      cfg_mirror = MIRROR_AT_RESET;
      cfg_port_a = PORT_A_AT_RESET;
      cfg_port_b = PORT_B_AT_RESET;
      clear_capture();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, under the first idle mix
      fill_directed_table();
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_REG) begin
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            build_frame(dir_rows[i].len, dir_rows[i].etype, dir_rows[i].ihl,
                        dir_rows[i].proto, dir_rows[i].sport, dir_rows[i].dport,
                        dir_rows[i].fill);
            send_frame(dir_rows[i].rx_q, dir_rows[i].typed, dir_rows[i].typed_v);
         end
      end

      // random phases: sender-light, receiver-light, then flat out
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               stall_pct     = 63;
               mask          = '1;
               pa            = 16'($urandom);
               pb            = 16'($urandom);
            end
            1: begin
               send_idle_pct = 63;
               stall_pct     = 30;
               mask          = {$urandom, $urandom};
               pa            = 16'h0000;
               pb            = 16'hFFFF;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               mask          = {$urandom, $urandom};
               pa            = 16'($urandom);
               pb            = pa;                 // both ports the same
            end
         endcase
         // upper data bits are junk for the 16-bit registers
         write_reg(ipc_pkg::CSR_SOCKET_MASK, mask);
         write_reg(ipc_pkg::CSR_MIRROR_ETYPE, {$urandom, 16'($urandom), 16'($urandom)});
         write_reg(ipc_pkg::CSR_PORT_A, {$urandom, 16'($urandom), pa});
         write_reg(ipc_pkg::CSR_PORT_B, {$urandom, 16'($urandom), pb});

         phase_bytes  = 0;
         phase_frames = 0;
         while (phase_bytes < RANDOM_BYTES / 3 || phase_frames < MIN_FRAMES) begin
            // now and then hold off until the DUT has nothing left in flight
            if (phase_frames == 1 || $urandom_range(15) == 0) wait_drained();
            build_random_frame();
            phase_bytes += frame_buf.size();
            phase_frames++;
            send_frame(QW'($urandom_range(63)), 1'b0, '0);
         end
      end

      // quiet tail: any stray verdict beat here is caught by the checker
      stall_pct = 0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d frame bytes in %0d frames (%0d directed rows), %0d verdicts checked",
               bytes_sent, frames_sent, dir_rows.size(), verdicts_seen);
      $display("masks empty/full/alternating/random, port and ethertype extremes, %0d drains",
               drain_pauses);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("PASS industrial_packet_classifier");
      end else begin
         $display("%0d mismatches, %0d verdicts owed", mismatch_count, pending_verdicts.size());
         $display("FAIL industrial_packet_classifier");
      end
      $finish;
   end

endmodule
